// ===== rtl/h2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Number of color channels: red, green, blue in that order.
  localparam int NCH = 3;

  // Segment of the hue ramp that a channel falls in.
  typedef enum logic [1:0] {
    RAMP_RISE,
    RAMP_TOP,
    RAMP_FALL,
    RAMP_BOTTOM
  } ramp_t;

endpackage

`default_nettype wire

// ===== rtl/h2r_hsl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel that carries one HSL pixel per transaction.
interface h2r_hsl_if #(
  parameter int W = 16
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] hue;
  logic [W-1:0] saturation;
  logic [W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input lightness,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/h2r_rgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel that carries one RGB pixel per transaction.
interface h2r_rgb_if #(
  parameter int W = 16
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] red;
  logic [W-1:0] green;
  logic [W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsl_to_rgb_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGB pixel converter.
// Input channel hsl (sink) takes one pixel per transaction: hue as a fraction of a
// turn, saturation and lightness with all ones meaning 1.0. Output channel rgb
// (source) gives one pixel per input pixel, in order, at the same scale.
// Both channels use valid/ready; a transaction happens when both are high.
// The datapath is a nine-stage pipeline, stages 0 to 8, that a pixel passes
// through in order before its result is presented. While the receiver keeps
// ready high, a new pixel can be accepted every cycle, giving a throughput of
// one pixel per clock; the rate is set by the pipeline registers around the
// lightness-saturation multiplier and the three ramp multipliers, one pass
// through each per pixel.
// When the receiver drops ready, the pipeline first fills its empty stages and
// keeps accepting pixels until every stage holds one; then hsl.ready goes low.
// Nothing is lost or repeated under a stall.
// The synchronous reset empties the pipeline by clearing the valid bits; the data registers are not reset.
// COMPONENT_BITS must match the W parameter of both interface instances.
module hsl_to_rgb_unit
  import h2r_pkg::*;
#(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  h2r_hsl_if.sink    hsl,
  h2r_rgb_if.source  rgb
);

  localparam int B      = COMPONENT_BITS;
  localparam int NSTAGE = 9;

  localparam logic [B-1:0]   FULL   = '1;
  localparam logic [B-1:0]   THIRD  = B'(((64'd1 << B) + 64'd1) / 64'd3);
  localparam logic [2*B-1:0] HALF_F = (2*B)'((64'd1 << (B - 1)) - 64'd1);
  localparam logic [2*B:0]   HALFQ  = (2*B+1)'(64'd1 << (B - 1));

  // Pipeline control.
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   adv;

  // Stage registers.
  logic [2*B-1:0] s0_p;
  logic [B-1:0]   s0_l, s0_s;
  logic           s0_lsmall;
  logic [B-1:0]   s0_t [NCH];

  logic [2*B-1:0] s1_x;
  logic [B-1:0]   s1_l, s1_s;
  logic           s1_lsmall;
  ramp_t          s1_code [NCH];
  logic [B:0]     s1_m [NCH];

  logic [B-1:0]   s2_ls, s2_l, s2_s;
  logic           s2_lsmall;
  ramp_t          s2_code [NCH];
  logic [B:0]     s2_m [NCH];

  logic [B-1:0]   s3_hi, s3_l;
  ramp_t          s3_code [NCH];
  logic [B:0]     s3_m [NCH];

  logic [B-1:0]   s4_hi, s4_lo;
  ramp_t          s4_code [NCH];
  logic [B:0]     s4_m [NCH];

  logic [B-1:0]   s5_span, s5_hi, s5_lo;
  ramp_t          s5_code [NCH];
  logic [B:0]     s5_m [NCH];

  logic [2*B:0]   s6_prod [NCH];
  logic [B-1:0]   s6_hi, s6_lo;
  ramp_t          s6_code [NCH];

  logic [B:0]     s7_r [NCH];
  logic [B-1:0]   s7_hi, s7_lo;
  ramp_t          s7_code [NCH];

  logic [B-1:0]   s8_c [NCH];

  // Next values of the combinational steps.
  logic [B-1:0]   t_next [NCH];
  ramp_t          code_next [NCH];
  logic [B:0]     m_next [NCH];
  logic [2*B:0]   q_sum;
  logic [B:0]     hi_raw;
  logic [B-1:0]   hi_next;
  logic [B+1:0]   lo_diff;
  logic [B-1:0]   lo_next;
  logic [2*B:0]   round_sum [NCH];
  logic [B+1:0]   ch_sum [NCH];
  logic [B-1:0]   c_next [NCH];

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    adv[NSTAGE] = rgb.ready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign hsl.ready = adv[0];
  assign rgb.valid = vld[NSTAGE-1];
  assign rgb.red   = s8_c[0];
  assign rgb.green = s8_c[1];
  assign rgb.blue  = s8_c[2];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= hsl.valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: hue offsets per channel.
  always_comb begin
    t_next[0] = hsl.hue + THIRD;
    t_next[1] = hsl.hue;
    t_next[2] = hsl.hue - THIRD;
  end

  // Stage 0: lightness times saturation and the lightness half test.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_p      <= {{B{1'b0}}, hsl.lightness} * {{B{1'b0}}, hsl.saturation};
      s0_l      <= hsl.lightness;
      s0_s      <= hsl.saturation;
      s0_lsmall <= {hsl.lightness, 1'b0} < {1'b0, FULL};
      s0_t      <= t_next;
    end
  end

  // Stage 1: ramp segment and ramp multiplier operand for each channel.
  always_comb begin
    logic [B+2:0] six_t;
    logic [B+1:0] three_t;
    logic [B+2:0] fall_d;
    for (int c = 0; c < NCH; c++) begin
      six_t   = {3'b000, s0_t[c]} * (B+3)'(6);
      three_t = {2'b00, s0_t[c]} * (B+2)'(3);
      fall_d  = ((B+3)'(1) << (B + 2)) - six_t;
      if (six_t[B+2:B] == 3'b000) begin
        code_next[c] = RAMP_RISE;
        m_next[c]    = six_t[B:0];
      end else if (!s0_t[c][B-1]) begin
        code_next[c] = RAMP_TOP;
        m_next[c]    = '0;
      end else if (!three_t[B+1]) begin
        code_next[c] = RAMP_FALL;
        m_next[c]    = fall_d[B:0];
      end else begin
        code_next[c] = RAMP_BOTTOM;
        m_next[c]    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_x      <= s0_p + HALF_F;
      s1_l      <= s0_l;
      s1_s      <= s0_s;
      s1_lsmall <= s0_lsmall;
      s1_code   <= code_next;
      s1_m      <= m_next;
    end
  end

  // Stage 2: divide by full scale, exact for quotients below 2^B.
  assign q_sum = {1'b0, s1_x} + (2*B+1)'(s1_x >> B) + (2*B+1)'(1);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_ls     <= q_sum[2*B-1:B];
      s2_l      <= s1_l;
      s2_s      <= s1_s;
      s2_lsmall <= s1_lsmall;
      s2_code   <= s1_code;
      s2_m      <= s1_m;
    end
  end

  // Stage 3: upper chroma bound, clamped to full scale.
  always_comb begin
    if (s2_lsmall) begin
      hi_raw = {1'b0, s2_l} + {1'b0, s2_ls};
    end else begin
      hi_raw = {1'b0, s2_l} + {1'b0, s2_s} - {1'b0, s2_ls};
    end
    hi_next = hi_raw[B] ? FULL : hi_raw[B-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_hi   <= hi_next;
      s3_l    <= s2_l;
      s3_code <= s2_code;
      s3_m    <= s2_m;
    end
  end

  // Stage 4: lower chroma bound, kept between zero and the upper bound.
  always_comb begin
    lo_diff = {1'b0, s3_l, 1'b0} - {2'b00, s3_hi};
    if (lo_diff[B+1]) begin
      lo_next = '0;
    end else if (lo_diff[B:0] > {1'b0, s3_hi}) begin
      lo_next = s3_hi;
    end else begin
      lo_next = lo_diff[B-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_hi   <= s3_hi;
      s4_lo   <= lo_next;
      s4_code <= s3_code;
      s4_m    <= s3_m;
    end
  end

  // Stage 5: chroma span.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_span <= s4_hi - s4_lo;
      s5_hi   <= s4_hi;
      s5_lo   <= s4_lo;
      s5_code <= s4_code;
      s5_m    <= s4_m;
    end
  end

  // Stage 6: one ramp multiplier per channel.
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int c = 0; c < NCH; c++) begin
        s6_prod[c] <= (2*B+1)'(s5_span) * (2*B+1)'(s5_m[c]);
      end
      s6_hi   <= s5_hi;
      s6_lo   <= s5_lo;
      s6_code <= s5_code;
    end
  end

  // Stage 7: round the ramp products to the component scale.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      round_sum[c] = s6_prod[c] + HALFQ;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int c = 0; c < NCH; c++) begin
        s7_r[c] <= round_sum[c][2*B:B];
      end
      s7_hi   <= s6_hi;
      s7_lo   <= s6_lo;
      s7_code <= s6_code;
    end
  end

  // Stage 8: pick the segment value and saturate at full scale.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ch_sum[c] = {2'b00, s7_lo} + {1'b0, s7_r[c]};
      case (s7_code[c])
        RAMP_RISE, RAMP_FALL: begin
          c_next[c] = (ch_sum[c] > {2'b00, FULL}) ? FULL : ch_sum[c][B-1:0];
        end
        RAMP_TOP: begin
          c_next[c] = s7_hi;
        end
        RAMP_BOTTOM: begin
          c_next[c] = s7_lo;
        end
        default: begin
          c_next[c] = s7_lo;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_c <= c_next;
    end
  end

  // An empty first stage always lets a transaction in.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> hsl.ready)
    else $error("input not ready although the first stage is empty");

  // The chroma bounds stay ordered once the lower bound is formed.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (s4_lo <= s4_hi))
    else $error("lower chroma bound above upper bound");

  // A blocked stage keeps its item.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !adv[5] |=> vld[5] && $stable(s5_span) && $stable(s5_lo))
    else $error("stalled span stage lost or changed its item");

  // The rounded ramp terms of the red and blue channels never exceed the chroma span.
  a_ramp_in_span: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> ({1'b0, s7_r[0]} <= {2'b00, s7_hi} - {2'b00, s7_lo}) &&
               ({1'b0, s7_r[2]} <= {2'b00, s7_hi} - {2'b00, s7_lo}))
    else $error("ramp term exceeds chroma span");

endmodule

`default_nettype wire
